>>> hw/rtl/s5hp_pkg.sv
`timescale 1ns / 1ps

package s5hp_pkg;

   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_BAD_VERSION = 3'd1;
   localparam logic [2:0] STATUS_BAD_COMMAND = 3'd2;
   localparam logic [2:0] STATUS_BAD_ATYP    = 3'd3;
   localparam logic [2:0] STATUS_JUNK        = 3'd4;

   localparam logic [7:0] SOCKS_VERSION   = 8'd5;
   localparam logic [7:0] CMD_CONNECT     = 8'd1;
   localparam logic [7:0] ATYP_IPV4       = 8'd1;
   localparam logic [7:0] ATYP_DOMAIN     = 8'd3;
   localparam logic [7:0] ATYP_IPV6       = 8'd4;
   localparam logic [7:0] IPV4_ADDR_BYTES = 8'd4;
   localparam logic [7:0] IPV6_ADDR_BYTES = 8'd16;

   localparam logic [7:0] METHOD_NO_AUTH  = 8'd0;
   localparam logic [7:0] METHOD_GSSAPI   = 8'd1;
   localparam logic [7:0] METHOD_USERPASS = 8'd2;

   localparam logic KIND_GREETING = 1'b0;
   localparam logic KIND_REQUEST  = 1'b1;

   typedef struct packed {
      logic       kind;
      logic       start_req;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        complete;
      logic [2:0]  auth_mask;
      logic [7:0]  address_type;
      logic        address_valid;
      logic [7:0]  address_byte;
      logic [7:0]  address_index;
      logic [7:0]  address_length;
      logic [15:0] dest_port;
   } rsp_type;

endpackage

>>> hw/rtl/socks5_handshake_parser_core.sv
`timescale 1ns / 1ps

// SOCKS5 handshake parser: takes one message byte per item and returns one
// status item per byte. Throughput is one item per clock cycle while the
// result is not stalled; an accepted item goes from an input register through
// the phase decoder into the result register. A stalled result holds the
// result register, and the input register keeps taking an item as long as the
// result register can drain. A byte with start_req high restarts parsing with
// the given kind; errors stay in status until the next start.
module socks5_handshake_parser_core
   import s5hp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_G_VER,
      PH_G_NM,
      PH_G_METH,
      PH_G_DONE,
      PH_R_VER,
      PH_R_CMD,
      PH_R_RSV,
      PH_R_ATYP,
      PH_R_ALEN,
      PH_R_ADDR,
      PH_R_PORT,
      PH_R_DONE,
      PH_ERR
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [2:0]  meth_ff, meth_in;
   logic [7:0]  atyp_ff, atyp_in;
   logic [15:0] port_ff, port_in;
   logic [2:0]  err_ff, err_in;

   logic        in_valid_ff;
   req_type     in_data_ff;
   logic        out_valid_ff;
   rsp_type     out_data_ff, out_data_in;

   logic        out_free;
   logic        advance;

   phase_type   base_phase;
   logic [7:0]  c;
   logic [7:0]  pos_inc;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign c = in_data_ff.data_byte;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      meth_in  = meth_ff;
      atyp_in  = atyp_ff;
      port_in  = port_ff;
      err_in   = err_ff;
      base_phase = phase_ff;
      out_data_in = '0;

      // start clears everything and opens the message of the given kind
      if (in_data_ff.start_req) begin
         pos_in  = '0;
         cnt_in  = '0;
         meth_in = '0;
         atyp_in = '0;
         port_in = '0;
         err_in  = STATUS_OK;
         base_phase = (in_data_ff.kind == KIND_REQUEST) ? PH_R_VER : PH_G_VER;
      end
      phase_in = base_phase;
      pos_inc  = pos_in + 8'd1;

      unique case (base_phase)
         PH_G_VER: begin
            if (c != SOCKS_VERSION) begin
               err_in   = STATUS_BAD_VERSION;
               phase_in = PH_ERR;
            end else begin
               phase_in = PH_G_NM;
            end
         end
         PH_G_NM: begin
            pos_in   = '0;
            cnt_in   = c;
            phase_in = (c == 8'd0) ? PH_G_DONE : PH_G_METH;
         end
         PH_G_METH: begin
            if (c == METHOD_NO_AUTH)  meth_in = meth_in | 3'b001;
            if (c == METHOD_GSSAPI)   meth_in = meth_in | 3'b010;
            if (c == METHOD_USERPASS) meth_in = meth_in | 3'b100;
            pos_in = pos_inc;
            if (pos_inc == cnt_in) phase_in = PH_G_DONE;
         end
         PH_R_VER: begin
            if (c != SOCKS_VERSION) begin
               err_in   = STATUS_BAD_VERSION;
               phase_in = PH_ERR;
            end else begin
               phase_in = PH_R_CMD;
            end
         end
         PH_R_CMD: begin
            if (c != CMD_CONNECT) begin
               err_in   = STATUS_BAD_COMMAND;
               phase_in = PH_ERR;
            end else begin
               phase_in = PH_R_RSV;
            end
         end
         PH_R_RSV: begin
            phase_in = PH_R_ATYP;
         end
         PH_R_ATYP: begin
            atyp_in = c;
            pos_in  = '0;
            if (c == ATYP_IPV4) begin
               cnt_in   = IPV4_ADDR_BYTES;
               phase_in = PH_R_ADDR;
            end else if (c == ATYP_DOMAIN) begin
               phase_in = PH_R_ALEN;
            end else if (c == ATYP_IPV6) begin
               cnt_in   = IPV6_ADDR_BYTES;
               phase_in = PH_R_ADDR;
            end else begin
               err_in   = STATUS_BAD_ATYP;
               phase_in = PH_ERR;
            end
         end
         PH_R_ALEN: begin
            pos_in   = '0;
            cnt_in   = c;
            phase_in = (c == 8'd0) ? PH_R_PORT : PH_R_ADDR;
         end
         PH_R_ADDR: begin
            out_data_in.address_valid = 1'b1;
            out_data_in.address_byte  = c;
            out_data_in.address_index = pos_in;
            pos_in = pos_inc;
            if (pos_inc == cnt_in) begin
               pos_in   = '0;
               phase_in = PH_R_PORT;
            end
         end
         PH_R_PORT: begin
            // port arrives high byte first
            if (pos_in == 8'd0) begin
               port_in = {c, 8'h00};
               pos_in  = 8'd1;
            end else begin
               port_in  = port_in | {8'h00, c};
               phase_in = PH_R_DONE;
            end
         end
         PH_G_DONE, PH_R_DONE: begin
            err_in   = STATUS_JUNK;
            phase_in = PH_ERR;
         end
         default: begin
         end
      endcase

      if (phase_in == PH_R_ADDR || phase_in == PH_R_PORT || phase_in == PH_R_DONE)
         out_data_in.address_length = cnt_in;

      out_data_in.status       = err_in;
      out_data_in.complete     = (err_in == STATUS_OK) &&
                                 (phase_in == PH_G_DONE || phase_in == PH_R_DONE);
      out_data_in.auth_mask    = meth_in;
      out_data_in.address_type = atyp_in;
      out_data_in.dest_port    = port_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         meth_ff      <= '0;
         atyp_ff      <= '0;
         port_ff      <= '0;
         err_ff       <= STATUS_OK;
      end else begin
         if (!in_valid_ff || out_free) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            cnt_ff   <= cnt_in;
            meth_ff  <= meth_in;
            atyp_ff  <= atyp_in;
            port_ff  <= port_in;
            err_ff   <= err_in;
         end
      end
   end

endmodule

>>> hw/rtl/s5hp_checker.sv
`timescale 1ns / 1ps

module s5hp_checker
   import s5hp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   a_complete_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.complete |-> rsp_data.status == STATUS_OK)
      else $error("complete with error status");

   // address bytes stay inside the announced length; other bytes carry none
   a_addr_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.address_valid ?
         (rsp_data.address_index < rsp_data.address_length) :
         (rsp_data.address_byte == 8'd0 && rsp_data.address_index == 8'd0)))
      else $error("address fields inconsistent");

   // input stalls only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

endmodule

bind socks5_handshake_parser_core s5hp_checker u_s5hp_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import s5hp_pkg::*;

   localparam int HOLD_CYCLES = 150;
   localparam int MAX_REPORTS = 10;

   typedef enum logic [3:0] {
      WAIT_START, G_VERSION, G_NMETHODS, G_METHODS, G_DONE,
      R_VERSION, R_COMMAND, R_RESERVED, R_ATYP, R_DOMAIN_LEN,
      R_ADDRESS, R_PORT, R_DONE, FAILED
   } parse_state_type;

   typedef struct packed {
      req_type item;
      logic    known;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // typed expectation that travels with the item on the bus
   logic    req_known;
   rsp_type req_want;

   // shadow of the parser state
   parse_state_type sh_phase;
   logic [7:0]      sh_pos;
   logic [7:0]      sh_count;
   logic [2:0]      sh_mask;
   logic [7:0]      sh_atyp;
   logic [15:0]     sh_port;
   logic [2:0]      sh_err;

   rsp_type      status_q[$];
   rsp_type      predicted;
   stim_row_type directed[$];
   int      mismatches = 0;
   int      results_seen = 0;
   int      items_sent = 0;
   int      send_idle_pct = 9;
   int      recv_idle_pct = 85;
   bit      hold_off_req = 1'b0;

   socks5_handshake_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic rsp_type parse_byte(req_type it);
      rsp_type    r;
      logic [7:0] b;
      r = '0;
      b = it.data_byte;
      if (it.start_req) begin
         sh_pos   = '0;
         sh_count = '0;
         sh_mask  = '0;
         sh_atyp  = '0;
         sh_port  = '0;
         sh_err   = STATUS_OK;
         sh_phase = (it.kind == KIND_REQUEST) ? R_VERSION : G_VERSION;
      end
      case (sh_phase)
         G_VERSION: begin
            if (b != SOCKS_VERSION) begin
               sh_err   = STATUS_BAD_VERSION;
               sh_phase = FAILED;
            end else sh_phase = G_NMETHODS;
         end
         G_NMETHODS: begin
            sh_pos   = '0;
            sh_count = b;
            sh_phase = (b == 8'd0) ? G_DONE : G_METHODS;
         end
         G_METHODS: begin
            if (b == METHOD_NO_AUTH) sh_mask[0] = 1'b1;
            else if (b == METHOD_GSSAPI) sh_mask[1] = 1'b1;
            else if (b == METHOD_USERPASS) sh_mask[2] = 1'b1;
            sh_pos = sh_pos + 8'd1;
            if (sh_pos == sh_count) sh_phase = G_DONE;
         end
         R_VERSION: begin
            if (b != SOCKS_VERSION) begin
               sh_err   = STATUS_BAD_VERSION;
               sh_phase = FAILED;
            end else sh_phase = R_COMMAND;
         end
         R_COMMAND: begin
            if (b != CMD_CONNECT) begin
               sh_err   = STATUS_BAD_COMMAND;
               sh_phase = FAILED;
            end else sh_phase = R_RESERVED;
         end
         R_RESERVED: sh_phase = R_ATYP;
         R_ATYP: begin
            sh_atyp = b;
            sh_pos  = '0;
            if (b == ATYP_IPV4) begin
               sh_count = IPV4_ADDR_BYTES;
               sh_phase = R_ADDRESS;
            end else if (b == ATYP_DOMAIN) begin
               sh_phase = R_DOMAIN_LEN;
            end else if (b == ATYP_IPV6) begin
               sh_count = IPV6_ADDR_BYTES;
               sh_phase = R_ADDRESS;
            end else begin
               sh_err   = STATUS_BAD_ATYP;
               sh_phase = FAILED;
            end
         end
         R_DOMAIN_LEN: begin
            sh_pos   = '0;
            sh_count = b;
            sh_phase = (b == 8'd0) ? R_PORT : R_ADDRESS;
         end
         R_ADDRESS: begin
            r.address_valid = 1'b1;
            r.address_byte  = b;
            r.address_index = sh_pos;
            sh_pos = sh_pos + 8'd1;
            if (sh_pos == sh_count) begin
               sh_pos   = '0;
               sh_phase = R_PORT;
            end
         end
         R_PORT: begin
            if (sh_pos == 8'd0) begin
               sh_port = {b, 8'h00};
               sh_pos  = 8'd1;
            end else begin
               sh_port  = sh_port | {8'h00, b};
               sh_phase = R_DONE;
            end
         end
         G_DONE, R_DONE: begin
            sh_err   = STATUS_JUNK;
            sh_phase = FAILED;
         end
         default: ;
      endcase
      if (sh_phase == R_ADDRESS || sh_phase == R_PORT || sh_phase == R_DONE)
         r.address_length = sh_count;
      r.status       = sh_err;
      r.complete     = (sh_err == STATUS_OK) && (sh_phase == G_DONE || sh_phase == R_DONE);
      r.auth_mask    = sh_mask;
      r.address_type = sh_atyp;
      r.dest_port    = sh_port;
      return r;
   endfunction

   function automatic string show(rsp_type r);
      return $sformatf({"st=%0d done=%0d mask=%0d atyp=%02h av=%0d ab=%02h ",
                        "ai=%0d alen=%0d port=%04h"},
                       r.status, r.complete, r.auth_mask, r.address_type, r.address_valid,
                       r.address_byte, r.address_index, r.address_length, r.dest_port);
   endfunction

   // predict on acceptance, compare on delivery
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = parse_byte(req_data);
            status_q.push_back(req_known ? req_want : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (status_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("result %0d arrived with nothing pending: %s",
                           results_seen, show(rsp_data));
            end else begin
               predicted = status_q.pop_front();
               if (rsp_data !== predicted) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("result %0d mismatch", results_seen);
                     $display("  expected %s", show(predicted));
                     $display("  actual   %s", show(rsp_data));
                  end
               end
            end
            results_seen++;
         end
      end
   end

   // receiver: random stall, or one long hold-off when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   function automatic stim_row_type row_of(logic kind, logic start, logic [7:0] b);
      stim_row_type s;
      s = '0;
      s.item.kind      = kind;
      s.item.start_req = start;
      s.item.data_byte = b;
      return s;
   endfunction

   function automatic stim_row_type row_want(logic kind, logic start, logic [7:0] b,
                                             logic [2:0] st, logic [2:0] mask,
                                             logic [7:0] atyp);
      stim_row_type s;
      s = row_of(kind, start, b);
      s.known             = 1'b1;
      s.want.status       = st;
      s.want.auth_mask    = mask;
      s.want.address_type = atyp;
      return s;
   endfunction

   function automatic req_type body_byte(logic [7:0] b);
      req_type it;
      it.kind      = 1'($urandom_range(1));
      it.start_req = 1'b0;
      it.data_byte = b;
      return it;
   endfunction

   task automatic send_row(stim_row_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s.item;
      req_known <= s.known;
      req_want  <= s.want;
      do @(posedge clock); while (req_stall);
   endtask

   // one message, mostly well formed; long_domain forces a 255-byte domain
   task automatic send_message(bit long_domain);
      req_type      msg[$];
      req_type      it;
      stim_row_type s;
      int           n;
      int           pick;
      int           idx;
      logic [7:0]   atyp;
      it = '0;
      it.kind      = long_domain ? KIND_REQUEST : logic'($urandom_range(1));
      it.start_req = 1'b1;
      it.data_byte = SOCKS_VERSION;
      msg.push_back(it);
      if (it.kind == KIND_GREETING) begin
         n = $urandom_range(0, 6);
         msg.push_back(body_byte(8'(n)));
         repeat (n)
            msg.push_back(body_byte(8'(($urandom_range(3) == 0) ?
                                       $urandom : $urandom_range(0, 3))));
      end else begin
         msg.push_back(body_byte(CMD_CONNECT));
         msg.push_back(body_byte(8'($urandom)));
         case (long_domain ? 1 : $urandom_range(2))
            0:       atyp = ATYP_IPV4;
            1:       atyp = ATYP_DOMAIN;
            default: atyp = ATYP_IPV6;
         endcase
         msg.push_back(body_byte(atyp));
         if (atyp == ATYP_DOMAIN) begin
            n = long_domain ? 255 : $urandom_range(0, 8);
            msg.push_back(body_byte(8'(n)));
         end else begin
            n = int'((atyp == ATYP_IPV4) ? IPV4_ADDR_BYTES : IPV6_ADDR_BYTES);
         end
         repeat (n) msg.push_back(body_byte(8'($urandom)));
         msg.push_back(body_byte(8'($urandom)));
         msg.push_back(body_byte(8'($urandom)));
      end
      pick = long_domain ? 99 : $urandom_range(99);
      if (pick < 10) begin
         // corrupt a header byte
         idx = $urandom_range(0, (msg.size() > 5) ? 4 : msg.size() - 1);
         msg[idx].data_byte = 8'($urandom);
      end else if (pick < 17) begin
         // cut short; the next start interrupts it
         n = $urandom_range(1, msg.size() - 1);
         while (msg.size() > n) void'(msg.pop_back());
      end else if (pick < 24) begin
         repeat ($urandom_range(1, 2)) msg.push_back(body_byte(8'($urandom)));
      end
      if ($urandom_range(99) < 5) begin
         s = '0;
         s.item = req_type'(10'($urandom));
         send_row(s);
      end
      foreach (msg[i]) begin
         s = '0;
         s.item = msg[i];
         send_row(s);
         items_sent++;
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      req_known = 1'b0;
      req_want  = '0;
      sh_phase  = WAIT_START;
      sh_pos    = '0;
      sh_count  = '0;
      sh_mask   = '0;
      sh_atyp   = '0;
      sh_port   = '0;
      sh_err    = STATUS_OK;

      // byte before any start is ignored
      directed.push_back(row_want(KIND_REQUEST, 1'b0, 8'hFF, STATUS_OK, 3'd0, 8'h00));
      // greeting with all three methods plus an unknown one, then junk
      directed.push_back(row_of(KIND_GREETING, 1'b1, SOCKS_VERSION));
      directed.push_back(row_of(KIND_REQUEST, 1'b0, 8'd4));
      directed.push_back(row_of(KIND_GREETING, 1'b0, METHOD_NO_AUTH));
      directed.push_back(row_of(KIND_GREETING, 1'b0, METHOD_GSSAPI));
      directed.push_back(row_of(KIND_GREETING, 1'b0, 8'hFF));
      directed.push_back(row_of(KIND_GREETING, 1'b0, METHOD_USERPASS));
      directed.push_back(row_want(KIND_GREETING, 1'b0, 8'hFF, STATUS_JUNK, 3'b111, 8'h00));
      directed.push_back(row_of(KIND_GREETING, 1'b0, SOCKS_VERSION));
      directed.push_back(row_want(KIND_GREETING, 1'b1, 8'h00, STATUS_BAD_VERSION, 3'd0, 8'h00));
      // zero method count completes on the count byte
      directed.push_back(row_of(KIND_GREETING, 1'b1, SOCKS_VERSION));
      directed.push_back(row_of(KIND_GREETING, 1'b0, 8'h00));
      directed.push_back(row_want(KIND_REQUEST, 1'b1, 8'hFF, STATUS_BAD_VERSION, 3'd0, 8'h00));
      directed.push_back(row_of(KIND_REQUEST, 1'b1, SOCKS_VERSION));
      directed.push_back(row_want(KIND_REQUEST, 1'b0, 8'h00, STATUS_BAD_COMMAND, 3'd0, 8'h00));
      // bad address type is still kept
      directed.push_back(row_of(KIND_REQUEST, 1'b1, SOCKS_VERSION));
      directed.push_back(row_of(KIND_REQUEST, 1'b0, CMD_CONNECT));
      directed.push_back(row_of(KIND_REQUEST, 1'b0, 8'hFF));
      directed.push_back(row_want(KIND_REQUEST, 1'b0, 8'hFF, STATUS_BAD_ATYP, 3'd0, 8'hFF));
      // zero domain length goes straight to the port
      directed.push_back(row_of(KIND_REQUEST, 1'b1, SOCKS_VERSION));
      directed.push_back(row_of(KIND_REQUEST, 1'b0, CMD_CONNECT));
      directed.push_back(row_of(KIND_REQUEST, 1'b0, 8'h00));
      directed.push_back(row_of(KIND_REQUEST, 1'b0, ATYP_DOMAIN));
      directed.push_back(row_of(KIND_REQUEST, 1'b0, 8'h00));
      directed.push_back(row_of(KIND_REQUEST, 1'b0, 8'hFF));
      directed.push_back(row_of(KIND_REQUEST, 1'b0, 8'hFF));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_row(directed[i]);

      while (items_sent < 130) send_message(1'b0);
      send_idle_pct = 85;
      recv_idle_pct = 9;
      while (items_sent < 260) send_message(1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // hold the result side while items keep coming
      hold_off_req = 1'b1;
      send_message(1'b1);
      while (items_sent < 550) send_message(1'b0);

      req_valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
